// ===== src/cfir_pkg.sv =====
`default_nettype none

package cfir_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int PROD_W      = 2 * SAMPLE_W;
	localparam int GAIN_W      = 16;
	localparam int INDEX_W     = 6;
	localparam int ROUND_SHIFT = 23;
	localparam int GAIN_LO_W   = 20;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COEFF  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} cfir_state_t;

	typedef struct packed {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] sample_i;
		logic signed [SAMPLE_W-1:0] sample_q;
		logic        [INDEX_W-1:0]  coeff_index;
		logic signed [SAMPLE_W-1:0] coeff_value;
	} cfir_in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_i;
		logic signed [SAMPLE_W-1:0] out_q;
		logic                       saturated;
	} cfir_out_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] i;
		logic signed [SAMPLE_W-1:0] q;
	} cfir_cplx_t;

	typedef struct packed {
		logic                       shift;
		logic                       wr;
		logic signed [SAMPLE_W-1:0] coeff;
	} cfir_cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/cfir_cell.sv =====
`default_nettype none

module cfir_cell #(
	parameter int ACC_W = 38
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  cfir_pkg::cfir_cell_ctl_t ctl,
	input  wire  cfir_pkg::cfir_cplx_t  x_in,
	output cfir_pkg::cfir_cplx_t        x_out,
	input  wire  signed [ACC_W-1:0]     psum_i_in,
	input  wire  signed [ACC_W-1:0]     psum_q_in,
	output logic signed [ACC_W-1:0]     psum_i_out,
	output logic signed [ACC_W-1:0]     psum_q_out
);

	cfir_pkg::cfir_cplx_t                       x_q;
	logic signed [cfir_pkg::SAMPLE_W-1:0]       w_q;
	logic signed [cfir_pkg::PROD_W-1:0]         prod_i_s1;
	logic signed [cfir_pkg::PROD_W-1:0]         prod_q_s1;
	logic signed [ACC_W-1:0]                    psum_i_q;
	logic signed [ACC_W-1:0]                    psum_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			w_q <= '0;
		end else begin
			if (ctl.shift) begin
				x_q <= x_in;
			end
			if (ctl.wr) begin
				w_q <= ctl.coeff;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_i_s1 <= x_q.i * w_q;
		prod_q_s1 <= x_q.q * w_q;
		psum_i_q  <= psum_i_in + ACC_W'(prod_i_s1);
		psum_q_q  <= psum_q_in + ACC_W'(prod_q_s1);
	end

	assign x_out      = x_q;
	assign psum_i_out = psum_i_q;
	assign psum_q_out = psum_q_q;

endmodule

`default_nettype wire

// ===== src/cfir_finish.sv =====
`default_nettype none

module cfir_finish #(
	parameter int ACC_W = 38
) (
	input  wire                                    clk,
	input  wire  signed [ACC_W-1:0]                acc,
	input  wire         [cfir_pkg::GAIN_W-1:0]     gain,
	output logic signed [cfir_pkg::SAMPLE_W-1:0]   value,
	output logic                                   clip
);

	localparam int LO_W = cfir_pkg::GAIN_LO_W;
	localparam int HI_W = ACC_W - LO_W;
	localparam int SC_W = ACC_W + cfir_pkg::GAIN_W + 1;
	localparam int Q_W  = SC_W - cfir_pkg::ROUND_SHIFT;

	localparam logic signed [SC_W-1:0] RND  = SC_W'(1) <<< (cfir_pkg::ROUND_SHIFT - 1);
	localparam logic signed [Q_W-1:0]  QMAX = Q_W'(32767);
	localparam logic signed [Q_W-1:0]  QMIN = Q_W'(-32768);

	logic        [LO_W+cfir_pkg::GAIN_W-1:0]   p_lo_s1;
	logic signed [HI_W+cfir_pkg::GAIN_W:0]     p_hi_s1;
	logic signed [SC_W-1:0]                    sum_s2;
	logic signed [Q_W-1:0]                     q_val;
	logic signed [cfir_pkg::SAMPLE_W-1:0]      value_s3;
	logic                                      clip_s3;

	assign q_val = Q_W'(sum_s2 >>> cfir_pkg::ROUND_SHIFT);

	always_ff @(posedge clk) begin
		p_lo_s1 <= acc[LO_W-1:0] * gain;
		p_hi_s1 <= $signed(acc[ACC_W-1:LO_W]) * $signed({1'b0, gain});
		sum_s2  <= (SC_W'(p_hi_s1) <<< LO_W)
			+ $signed({{(SC_W-LO_W-cfir_pkg::GAIN_W){1'b0}}, p_lo_s1}) + RND;
		if (q_val > QMAX) begin
			value_s3 <= 16'sh7FFF;
			clip_s3  <= 1'b1;
		end else if (q_val < QMIN) begin
			value_s3 <= -16'sh8000;
			clip_s3  <= 1'b1;
		end else begin
			value_s3 <= q_val[cfir_pkg::SAMPLE_W-1:0];
			clip_s3  <= 1'b0;
		end
	end

	assign value = value_s3;
	assign clip  = clip_s3;

endmodule

`default_nettype wire

// ===== src/complex_fir_filter.sv =====
// A sample word sends a partial-sum wave through the chain of TAP_COUNT cells,
// the three-stage gain pipeline and the output register. The input stays stalled
// until that result is loaded, so no new word is taken during a calculation;
// a pending stalled result holds the input stalled until it is taken.
// A coefficient word is taken without leaving idle and gives no result.
// Reset clears the delay line and the weights to zero and sets the gain to 1.0.
`default_nettype none

module complex_fir_filter #(
	parameter int TAP_COUNT = 48
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  cfir_pkg::cfir_in_word_t in_word,
	output logic                          out_valid,
	input  wire                           out_stall,
	output cfir_pkg::cfir_out_word_t      out_word,
	input  wire                           cfg_we,
	input  wire  [cfir_pkg::GAIN_W-1:0]   cfg_wdata
);

	localparam int ACC_W = cfir_pkg::PROD_W + $clog2(TAP_COUNT);
	localparam int CNT_W = $clog2(TAP_COUNT + 5);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAP_COUNT + 4);

	cfir_pkg::cfir_state_t             state_q;
	cfir_pkg::cfir_state_t             state_d;
	logic [CNT_W-1:0]                  cnt_q;
	logic [CNT_W-1:0]                  cnt_d;
	logic [cfir_pkg::GAIN_W-1:0]       gain_q;
	logic                              in_accept;
	logic                              sample_acc;
	logic                              coeff_acc;
	logic                              load;
	logic                              out_valid_q;
	cfir_pkg::cfir_out_word_t          out_word_q;
	cfir_pkg::cfir_cplx_t              new_x;
	cfir_pkg::cfir_cplx_t              x_chain [TAP_COUNT];
	cfir_pkg::cfir_cell_ctl_t          ctl [TAP_COUNT];
	logic signed [ACC_W-1:0]           psum_i [TAP_COUNT+1];
	logic signed [ACC_W-1:0]           psum_q [TAP_COUNT+1];
	logic signed [cfir_pkg::SAMPLE_W-1:0] fin_i;
	logic signed [cfir_pkg::SAMPLE_W-1:0] fin_q;
	logic                              clip_i;
	logic                              clip_q;

	assign in_stall   = (state_q != cfir_pkg::ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign sample_acc = in_accept && (in_word.kind == cfir_pkg::KIND_SAMPLE);
	assign coeff_acc  = in_accept && (in_word.kind == cfir_pkg::KIND_COEFF);

	assign new_x.i   = in_word.sample_i;
	assign new_x.q   = in_word.sample_q;
	assign psum_i[0] = '0;
	assign psum_q[0] = '0;

	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
		assign ctl[k].shift = sample_acc;
		assign ctl[k].wr    = coeff_acc && (32'(in_word.coeff_index) == k);
		assign ctl[k].coeff = in_word.coeff_value;

		cfir_cell #(
			.ACC_W(ACC_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[k]),
			.x_in      ((k == TAP_COUNT - 1) ? new_x : x_chain[(k + 1) % TAP_COUNT]),
			.x_out     (x_chain[k]),
			.psum_i_in (psum_i[k]),
			.psum_q_in (psum_q[k]),
			.psum_i_out(psum_i[k+1]),
			.psum_q_out(psum_q[k+1])
		);
	end

	cfir_finish #(
		.ACC_W(ACC_W)
	) u_finish_i (
		.clk  (clk),
		.acc  (psum_i[TAP_COUNT]),
		.gain (gain_q),
		.value(fin_i),
		.clip (clip_i)
	);

	cfir_finish #(
		.ACC_W(ACC_W)
	) u_finish_q (
		.clk  (clk),
		.acc  (psum_q[TAP_COUNT]),
		.gain (gain_q),
		.value(fin_q),
		.clip (clip_q)
	);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		load    = 1'b0;
		case (state_q)
			cfir_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (sample_acc) begin
					state_d = cfir_pkg::ST_CALC;
				end
			end
			cfir_pkg::ST_CALC: begin
				if (cnt_q == CNT_LAST) begin
					if (!out_valid_q || !out_stall) begin
						load    = 1'b1;
						cnt_d   = '0;
						state_d = cfir_pkg::ST_IDLE;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = cfir_pkg::ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfir_pkg::ST_IDLE;
			cnt_q       <= '0;
			gain_q      <= cfir_pkg::GAIN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q.out_i     <= fin_i;
			out_word_q.out_q     <= fin_q;
			out_word_q.saturated <= clip_i || clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_sample_starts_calc: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc |=> (state_q == cfir_pkg::ST_CALC) && (cnt_q == '0))
		else $error("sample word did not start a calculation");

	a_result_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cfir_pkg::ST_CALC && cnt_q == CNT_LAST))
		else $error("result raised outside the end of a calculation");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cfir_pkg::ST_IDLE) |-> (cnt_q == '0))
		else $error("counter running while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !load)
		else $error("pending result overwritten");

endmodule

`default_nettype wire
